// ----- hdl/ssfs_pkg.sv -----
package ssfs_pkg;

    localparam int MAX_POINTS_DEF  = 256;
    localparam int STATE_WIDTH_DEF = 32;
    localparam int COEF_W          = 32;
    localparam int FRAC_BITS       = 24;
    localparam int SAMPLE_W        = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int COUNT_W         = 9;
    localparam int INDEX_W         = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_GAIN        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_GAIN         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_CENTER_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_NEAR_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PICKUP_INDEX     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EXCITE_INDEX     = 3'd7;

    localparam logic [COUNT_W-1:0] POINT_COUNT_RST  = 9'd64;
    localparam logic [INDEX_W-1:0] PICKUP_INDEX_RST = 8'd32;
    localparam logic [INDEX_W-1:0] EXCITE_INDEX_RST = 8'd21;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PLAY = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXCITE,
        S_FETCH,
        S_SHIFT,
        S_MAC,
        S_DRAIN,
        S_WRITE,
        S_PICK,
        S_PICKD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic sub;
    } t_mac_ctl;

endpackage

// ----- hdl/ssfs_bank.sv -----
module ssfs_bank
    import ssfs_pkg::*;
#(
    parameter int DEPTH = MAX_POINTS_DEF,
    parameter int WIDTH = STATE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ssfs_mac.sv -----
module ssfs_mac
    import ssfs_pkg::*;
#(
    parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [STATE_WIDTH:0]   i_opnd,
    input  logic signed [COEF_W-1:0]      i_coef,
    output logic signed [STATE_WIDTH-1:0] o_result
);

    localparam int PW  = STATE_WIDTH + 1 + COEF_W;
    localparam int ACW = PW + 3;

    logic signed [PW-1:0]  r_prod;
    logic                  r_pvalid;
    logic                  r_first;
    logic                  r_sub;
    logic signed [ACW-1:0] r_acc;

    logic signed [ACW-1:0] w_term;
    logic signed [ACW-1:0] w_base;
    logic signed [ACW-1:0] w_round;
    logic signed [ACW-1:0] w_shift;
    logic signed [ACW-1:0] w_smax;
    logic signed [ACW-1:0] w_smin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= PW'(i_opnd) * PW'(i_coef);
        r_first <= i_ctl.first;
        r_sub   <= i_ctl.sub;
        if (r_pvalid) begin
            r_acc <= w_base + w_term;
        end
    end

    always_comb begin
        w_term  = r_sub ? -ACW'(r_prod) : ACW'(r_prod);
        w_base  = r_first ? '0 : r_acc;
        w_round = r_acc + (ACW'(1) <<< (FRAC_BITS - 1));
        w_shift = w_round >>> FRAC_BITS;
        w_smax  = $signed({{(ACW-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}});
        w_smin  = ~w_smax;
        if (w_shift > w_smax) begin
            o_result = w_smax[STATE_WIDTH-1:0];
        end else if (w_shift < w_smin) begin
            o_result = w_smin[STATE_WIDTH-1:0];
        end else begin
            o_result = w_shift[STATE_WIDTH-1:0];
        end
    end

endmodule

// ----- hdl/stiff_string_fdtd_synth_core.sv -----
// Damped stiff string synthesizer on a finite-difference grid.
// Input channel: i_in_valid with o_in_stall carries one word of i_op and
// i_play_flag. A tick word (op 0) yields one o_sample word on the output
// channel (o_out_valid with i_out_stall); a play word (op 1) yields none.
// Configuration words are written through i_cfg_valid/o_cfg_ready; the user
// must write them only while idle, which the block itself does not enforce.
// A tick while playing, with a count of five or more, takes each interior
// point through five products on the single shared multiply-accumulate
// unit plus a fetch, shift, drain and write-back step; below five it goes
// straight to the pickup read. A tick while stopped returns zero.
// Starting or stopping play runs a clearing pass over every address of the
// three buffer memories, plus an excitation step when starting.
// After reset the same clearing pass runs before the first word is taken;
// configuration returns to its reset values at once.
// The result sits in an output register; while the receiver stalls it holds,
// and the next input word may still be accepted and worked on up to the
// point where its own result needs the register.
module stiff_string_fdtd_synth_core
    import ssfs_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int STATE_WIDTH = STATE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_op,
    input  logic                       i_play_flag,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_sample,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SW  = STATE_WIDTH;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = ($clog2(MAX_POINTS + 1) > COUNT_W) ? $clog2(MAX_POINTS + 1) : COUNT_W;
    localparam int VW  = (SW > 26) ? SW : 26;
    localparam logic [1:0] ROLE_NX = 2'd0;
    localparam logic [1:0] ROLE_CU = 2'd1;
    localparam logic [1:0] ROLE_PV = 2'd2;
    localparam logic [SW-1:0] K_ONE = (SW > FRAC_BITS + 1) ?
        SW'(64'd1 << FRAC_BITS) : SW'((64'd1 << (SW - 1)) - 64'd1);

    t_state r_state;
    t_state n_state;

    logic signed [COEF_W-1:0] r_coef [5];
    logic [COUNT_W-1:0]       r_point_count;
    logic [INDEX_W-1:0]       r_pickup_index;
    logic [INDEX_W-1:0]       r_excite_index;

    logic                       r_playing;
    logic                       r_excite_pending;
    logic [1:0]                 r_rot;
    logic [AW-1:0]              r_caddr;
    logic [AW-1:0]              r_addr;
    logic [AW-1:0]              r_j;
    logic [2:0]                 r_phase;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic signed [SAMPLE_W-1:0] r_pend;
    logic signed [SW-1:0]       r_cw [5];
    logic signed [SW-1:0]       r_pw [4];

    logic [1:0]           w_r;
    logic [CW-1:0]        w_n;
    logic                 w_pick_ok;
    logic                 w_exc_ok;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_more;
    logic                 w_clear_done;

    logic [AW-1:0]        w_addr  [3];
    logic                 w_we    [3];
    logic [SW-1:0]        w_wdata [3];
    logic [SW-1:0]        w_rd    [3];
    logic [1:0]           w_cu_sel;
    logic [1:0]           w_pv_sel;
    logic signed [SW-1:0] w_cu_rd;
    logic signed [SW-1:0] w_pv_rd;
    logic signed [SW-1:0] w_nx_rd;

    t_mac_ctl             w_mac_ctl;
    logic signed [SW:0]   w_opnd;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [SW-1:0] w_mac_res;

    logic signed [VW-1:0] w_v;
    logic signed [VW-1:0] w_q;
    logic signed [SAMPLE_W-1:0] w_sample;

    function automatic logic [1:0] f_role(input logic [1:0] b, input logic [1:0] r);
        logic [2:0] d;
        d = {1'b0, b} + 3'd3 - {1'b0, r};
        return (d >= 3'd3) ? 2'(d - 3'd3) : d[1:0];
    endfunction

    function automatic logic [1:0] f_mod3_inc(input logic [1:0] r, input logic [1:0] k);
        logic [2:0] d;
        d = {1'b0, r} + {1'b0, k};
        return (d >= 3'd3) ? 2'(d - 3'd3) : d[1:0];
    endfunction

    assign w_r          = (r_rot == 2'd3) ? 2'd0 : r_rot;
    assign w_n          = (CW'(r_point_count) > CW'(MAX_POINTS)) ?
                          CW'(MAX_POINTS) : CW'(r_point_count);
    assign w_pick_ok    = CW'(r_pickup_index) < w_n;
    assign w_exc_ok     = CW'(r_excite_index) < w_n;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_more       = (CW'(r_j) + CW'(3)) < w_n;
    assign w_clear_done = r_caddr == AW'(MAX_POINTS - 1);
    assign w_cu_sel     = f_mod3_inc(w_r, 2'd1);
    assign w_pv_sel     = f_mod3_inc(w_r, 2'd2);
    assign w_cu_rd      = w_rd[w_cu_sel];
    assign w_pv_rd      = w_rd[w_pv_sel];
    assign w_nx_rd      = w_rd[w_r];

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;

    for (genvar b = 0; b < 3; b++) begin : g_bank
        ssfs_bank #(
            .DEPTH (MAX_POINTS),
            .WIDTH (SW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_addr  (w_addr[b]),
            .i_wdata (w_wdata[b]),
            .o_rdata (w_rd[b])
        );
    end

    ssfs_mac #(
        .STATE_WIDTH (SW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mac_ctl),
        .i_opnd   (w_opnd),
        .i_coef   (w_coef),
        .o_result (w_mac_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clear_done) begin
                    n_state = r_excite_pending ? S_EXCITE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_op == OP_PLAY) begin
                        if (r_playing != i_play_flag) begin
                            n_state = S_CLEAR;
                        end else if (r_playing) begin
                            n_state = S_EXCITE;
                        end
                    end else if (!r_playing) begin
                        n_state = S_EMIT;
                    end else if (w_n >= CW'(5)) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_PICK;
                    end
                end
            end
            S_EXCITE: n_state = S_IDLE;
            S_FETCH:  n_state = S_SHIFT;
            S_SHIFT:  n_state = (r_addr >= AW'(4)) ? S_MAC : S_FETCH;
            S_MAC:    n_state = (r_phase == 3'd4) ? S_DRAIN : S_MAC;
            S_DRAIN:  n_state = S_WRITE;
            S_WRITE:  n_state = w_more ? S_FETCH : S_PICK;
            S_PICK:   n_state = S_PICKD;
            S_PICKD:  n_state = S_EMIT;
            S_EMIT:   n_state = w_out_free ? S_IDLE : S_EMIT;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_in_stall      = r_state != S_IDLE;
        w_mac_ctl.valid = r_state == S_MAC;
        w_mac_ctl.first = r_phase == 3'd0;
        w_mac_ctl.sub   = 1'b0;
        w_opnd          = '0;
        w_coef          = r_coef[0];
        case (r_phase)
            3'd0: begin
                w_opnd = {r_cw[2][SW-1], r_cw[2]};
                w_coef = r_coef[0];
            end
            3'd1: begin
                w_opnd = {r_cw[1][SW-1], r_cw[1]} + {r_cw[3][SW-1], r_cw[3]};
                w_coef = r_coef[1];
            end
            3'd2: begin
                w_opnd = {r_cw[0][SW-1], r_cw[0]} + {r_cw[4][SW-1], r_cw[4]};
                w_coef = r_coef[2];
                w_mac_ctl.sub = 1'b1;
            end
            3'd3: begin
                w_opnd = {r_pw[1][SW-1], r_pw[1]};
                w_coef = r_coef[3];
            end
            3'd4: begin
                w_opnd = {r_pw[0][SW-1], r_pw[0]} + {r_pw[2][SW-1], r_pw[2]};
                w_coef = r_coef[4];
                w_mac_ctl.sub = 1'b1;
            end
            default: begin
                w_opnd = '0;
            end
        endcase
        for (int b = 0; b < 3; b++) begin
            w_we[b]    = 1'b0;
            w_wdata[b] = w_mac_res;
            w_addr[b]  = r_addr;
            if (r_state == S_CLEAR) begin
                w_we[b]    = 1'b1;
                w_wdata[b] = '0;
                w_addr[b]  = r_caddr;
            end else begin
                case (f_role(2'(b), w_r))
                    ROLE_NX: begin
                        w_addr[b] = (r_state == S_PICK) ? AW'(r_pickup_index) : r_j;
                        w_we[b]   = r_state == S_WRITE;
                    end
                    ROLE_CU: begin
                        if (r_state == S_EXCITE) begin
                            w_addr[b]  = AW'(r_excite_index);
                            w_wdata[b] = K_ONE;
                            w_we[b]    = w_exc_ok;
                        end
                    end
                    ROLE_PV: begin
                        w_addr[b] = r_addr;
                    end
                    default: begin
                        w_addr[b] = r_addr;
                    end
                endcase
            end
        end
    end

    always_comb begin
        w_v = w_pick_ok ? VW'(w_nx_rd) : '0;
        if (w_v > (VW'(1) <<< FRAC_BITS)) begin
            w_v = VW'(1) <<< FRAC_BITS;
        end else if (w_v < -(VW'(1) <<< FRAC_BITS)) begin
            w_v = -(VW'(1) <<< FRAC_BITS);
        end
        w_q = (w_v + VW'(256)) >>> 9;
        if (w_q > VW'(32767)) begin
            w_sample = 16'sh7fff;
        end else begin
            w_sample = w_q[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_playing        <= 1'b0;
            r_excite_pending <= 1'b0;
            r_rot            <= 2'd0;
            r_caddr          <= '0;
            r_addr           <= '0;
            r_j              <= '0;
            r_phase          <= 3'd0;
            r_out_valid      <= 1'b0;
            for (int k = 0; k < 5; k++) begin
                r_coef[k] <= '0;
            end
            r_point_count  <= POINT_COUNT_RST;
            r_pickup_index <= PICKUP_INDEX_RST;
            r_excite_index <= EXCITE_INDEX_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER_GAIN:      r_coef[0] <= i_cfg_data;
                    REG_NEAR_GAIN:        r_coef[1] <= i_cfg_data;
                    REG_FAR_GAIN:         r_coef[2] <= i_cfg_data;
                    REG_PAST_CENTER_GAIN: r_coef[3] <= i_cfg_data;
                    REG_PAST_NEAR_GAIN:   r_coef[4] <= i_cfg_data;
                    REG_POINT_COUNT:      r_point_count <= i_cfg_data[COUNT_W-1:0];
                    REG_PICKUP_INDEX:     r_pickup_index <= i_cfg_data[INDEX_W-1:0];
                    REG_EXCITE_INDEX:     r_excite_index <= i_cfg_data[INDEX_W-1:0];
                    default:              r_point_count <= r_point_count;
                endcase
            end
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_caddr <= r_caddr + AW'(1);
                end
                S_IDLE: begin
                    r_addr  <= '0;
                    r_j     <= AW'(2);
                    r_phase <= 3'd0;
                    if (w_accept && i_op == OP_PLAY && r_playing != i_play_flag) begin
                        r_playing        <= i_play_flag;
                        r_excite_pending <= i_play_flag;
                        r_caddr          <= '0;
                        r_rot            <= 2'd0;
                    end
                end
                S_EXCITE: begin
                    r_excite_pending <= 1'b0;
                end
                S_SHIFT: begin
                    r_addr <= r_addr + AW'(1);
                end
                S_MAC: begin
                    r_phase <= r_phase + 3'd1;
                end
                S_WRITE: begin
                    r_phase <= 3'd0;
                    r_j     <= r_j + AW'(1);
                end
                S_PICKD: begin
                    r_rot <= f_mod3_inc(w_r, 2'd2);
                end
                default: begin
                    r_phase <= r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SHIFT) begin
            for (int k = 0; k < 4; k++) begin
                r_cw[k] <= r_cw[k+1];
            end
            r_cw[4] <= w_cu_rd;
            for (int k = 0; k < 3; k++) begin
                r_pw[k] <= r_pw[k+1];
            end
            r_pw[3] <= w_pv_rd;
        end
        if (r_state == S_IDLE) begin
            r_pend <= '0;
        end else if (r_state == S_PICKD) begin
            r_pend <= w_sample;
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out_sample <= r_pend;
        end
    end

endmodule

// ----- hdl/ssfs_checker.sv -----
module ssfs_checker
    import ssfs_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_op,
    input logic                       i_play_flag,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_sample
);

    logic w_accept;
    assign w_accept = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample))
        else $error("Stalled output word changed or was dropped.");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("Block did not start its clearing pass after reset.");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_op == OP_TICK |=> o_in_stall)
        else $error("Input taken again before a tick word was finished.");

    a_play_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_op == OP_PLAY && i_play_flag |=> o_in_stall)
        else $error("Play start did not clear or excite the string.");

endmodule

bind stiff_string_fdtd_synth_core ssfs_checker u_ssfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_op        (i_op),
    .i_play_flag (i_play_flag),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sample    (o_sample)
);

// ----- tb/sv/string_model_check.sv -----
`timescale 1ns / 1ps

module string_model_check
    import ssfs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_op,
    input  logic                       i_play_flag,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_mismatches,
    output int                         o_pending
);

    localparam int GRID = MAX_POINTS_DEF;
    localparam int SW   = STATE_WIDTH_DEF;

    typedef logic signed [79:0]   t_wide;
    typedef logic signed [SW-1:0] t_disp;

    localparam t_wide DISP_HI   = (t_wide'(1) <<< (SW - 1)) - t_wide'(1);
    localparam t_wide DISP_LO   = -DISP_HI - t_wide'(1);
    localparam t_wide UNIT      = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide SAMPLE_HI = t_wide'(32767);
    localparam t_wide SAMPLE_LO = t_wide'(-32768);

    t_disp                      strings [3][GRID];
    int                         rotation;
    logic                       playing;
    logic signed [COEF_W-1:0]   center_w, near_w, far_w, past_w, past_near_w;
    logic [COUNT_W-1:0]         point_count;
    logic [INDEX_W-1:0]         pickup_at, excite_at;
    logic signed [SAMPLE_W-1:0] pending_samples [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         mismatches = 0;

    function automatic int used_points();
        return (point_count > GRID) ? GRID : int'(point_count);
    endfunction

    function automatic void silence_string();
        for (int b = 0; b < 3; b++) begin
            for (int j = 0; j < GRID; j++) begin
                strings[b][j] = '0;
            end
        end
        rotation = 0;
    endfunction

    function automatic void strike_string();
        if (excite_at < used_points()) begin
            strings[(rotation + 1) % 3][excite_at] = t_disp'(UNIT);
        end
    endfunction

    function automatic t_disp round_state(input t_wide acc);
        t_wide r;
        r = (acc + (t_wide'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (r > DISP_HI) r = DISP_HI;
        if (r < DISP_LO) r = DISP_LO;
        return t_disp'(r);
    endfunction

    // One audio step: next = stencil(current, previous), then the roles rotate.
    function automatic logic signed [SAMPLE_W-1:0] advance_string();
        int    r, nx, cu, pv, n;
        t_wide acc, v;
        r  = rotation % 3;
        nx = r;
        cu = (r + 1) % 3;
        pv = (r + 2) % 3;
        n  = used_points();
        for (int j = 2; j + 2 < n; j++) begin
            acc = t_wide'(strings[cu][j]) * t_wide'(center_w)
                + (t_wide'(strings[cu][j+1]) + t_wide'(strings[cu][j-1])) * t_wide'(near_w)
                - (t_wide'(strings[cu][j+2]) + t_wide'(strings[cu][j-2])) * t_wide'(far_w)
                + t_wide'(strings[pv][j]) * t_wide'(past_w)
                - (t_wide'(strings[pv][j+1]) + t_wide'(strings[pv][j-1]))
                  * t_wide'(past_near_w);
            strings[nx][j] = round_state(acc);
        end
        v = '0;
        if (pickup_at < n) begin
            v = t_wide'(strings[nx][pickup_at]);
            if (v > UNIT) v = UNIT;
            if (v < -UNIT) v = -UNIT;
        end
        rotation = (r + 2) % 3;
        v = (v + t_wide'(256)) >>> 9;
        if (v > SAMPLE_HI) v = SAMPLE_HI;
        if (v < SAMPLE_LO) v = SAMPLE_LO;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic take_word(input logic op, input logic flag);
        if (op == OP_PLAY) begin
            if (!playing) begin
                if (flag) begin
                    silence_string();
                    strike_string();
                    playing = 1'b1;
                end
            end else if (!flag) begin
                playing = 1'b0;
                silence_string();
            end else begin
                strike_string();
            end
        end else if (playing) begin
            pending_samples.push_back(advance_string());
        end else begin
            pending_samples.push_back('0);
        end
    endtask

    task automatic report_mismatch(input string what,
                                   input logic signed [SAMPLE_W-1:0] got,
                                   input logic signed [SAMPLE_W-1:0] expected_val);
        $display("mismatch at %0t: %s, got %0d, expected %0d",
                 $time, what, got, expected_val);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            silence_string();
            playing     = 1'b0;
            center_w    = '0;
            near_w      = '0;
            far_w       = '0;
            past_w      = '0;
            past_near_w = '0;
            point_count = POINT_COUNT_RST;
            pickup_at   = PICKUP_INDEX_RST;
            excite_at   = EXCITE_INDEX_RST;
            pending_samples.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_samples.size() == 0) begin
                    report_mismatch("sample word with no tick waiting", i_sample, '0);
                end else begin
                    want = pending_samples.pop_front();
                    if (i_sample !== want) begin
                        report_mismatch("sample", i_sample, want);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CENTER_GAIN:      center_w    = i_cfg_data;
                    REG_NEAR_GAIN:        near_w      = i_cfg_data;
                    REG_FAR_GAIN:         far_w       = i_cfg_data;
                    REG_PAST_CENTER_GAIN: past_w      = i_cfg_data;
                    REG_PAST_NEAR_GAIN:   past_near_w = i_cfg_data;
                    REG_POINT_COUNT:      point_count = i_cfg_data[COUNT_W-1:0];
                    REG_PICKUP_INDEX:     pickup_at   = i_cfg_data[INDEX_W-1:0];
                    REG_EXCITE_INDEX:     excite_at   = i_cfg_data[INDEX_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                take_word(i_op, i_play_flag);
            end
        end
        o_pending    = pending_samples.size();
        o_mismatches = mismatches;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ssfs_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int QUIET_CYCLES = MAX_POINTS_DEF + 40;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       i_op        = 1'b0;
    logic                       i_play_flag = 1'b0;
    logic                       i_out_stall = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic                       o_cfg_ready;
    logic signed [SAMPLE_W-1:0] o_sample;

    int   fails;
    int   pending;
    int   cycle_count  = 0;
    int   random_words = 0;
    int   stall_left   = 0;
    int   active_count = int'(POINT_COUNT_RST);
    logic calm         = 1'b0;
    logic sounding     = 1'b0;

    always #6 i_clk = ~i_clk;

    stiff_string_fdtd_synth_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_play_flag (i_play_flag),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample    (o_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    string_model_check model_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_play_flag  (i_play_flag),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_sample     (o_sample),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (fails),
        .o_pending    (pending)
    );

    function automatic int pick_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall_left  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 50);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic op, input logic flag);
        int gap;
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_op        <= op;
        i_play_flag <= flag;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A play word can still be clearing the buffers after the last sample.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] gain_value(input logic [CFG_IDX_W-1:0] which);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20) return $urandom();
        if (roll < 28) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        case (which)
            REG_CENTER_GAIN:      return 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF);
            REG_NEAR_GAIN:        return $urandom_range(0, 32'h0040_0000);
            REG_FAR_GAIN:         return $urandom_range(0, 32'h0008_0000);
            REG_PAST_CENTER_GAIN: return 32'hFF00_0000 + $urandom_range(0, 32'h0010_0000);
            default:              return $urandom_range(0, 32'h0008_0000);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] index_value(input int top_idx);
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, top_idx);
        return $urandom_range(0, 255);
    endfunction

    task automatic write_random_setup();
        logic [COUNT_W-1:0] cnt;
        int                 roll, top_idx;
        roll = $urandom_range(0, 99);
        if (roll < 8) cnt = COUNT_W'($urandom_range(0, 4));
        else if (roll < 16) cnt = COUNT_W'($urandom_range(200, 511));
        else cnt = COUNT_W'($urandom_range(5, 48));
        top_idx = (cnt > 255) ? 255 : ((cnt == 0) ? 0 : int'(cnt) - 1);
        write_reg(REG_POINT_COUNT, CFG_DATA_W'(cnt));
        if ($urandom_range(0, 9) < 8) write_reg(REG_PICKUP_INDEX, index_value(top_idx));
        if ($urandom_range(0, 9) < 8) write_reg(REG_EXCITE_INDEX, index_value(top_idx));
        if ($urandom_range(0, 9) < 7) write_reg(REG_CENTER_GAIN, gain_value(REG_CENTER_GAIN));
        if ($urandom_range(0, 9) < 7) write_reg(REG_NEAR_GAIN, gain_value(REG_NEAR_GAIN));
        if ($urandom_range(0, 9) < 7) write_reg(REG_FAR_GAIN, gain_value(REG_FAR_GAIN));
        if ($urandom_range(0, 9) < 7) begin
            write_reg(REG_PAST_CENTER_GAIN, gain_value(REG_PAST_CENTER_GAIN));
        end
        if ($urandom_range(0, 9) < 7) begin
            write_reg(REG_PAST_NEAR_GAIN, gain_value(REG_PAST_NEAR_GAIN));
        end
        active_count = int'(cnt);
    endtask

    task automatic random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (!sounding) begin
            if (roll < 70) begin
                send_word(OP_PLAY, 1'b1);
                sounding = 1'b1;
                random_words++;
            end else if (roll < 80) begin
                send_word(OP_PLAY, 1'b0);
            end else begin
                send_word(OP_TICK, 1'($urandom_range(0, 1)));
                random_words++;
            end
        end else begin
            if (roll < 84) begin
                send_word(OP_TICK, 1'($urandom_range(0, 1)));
            end else if (roll < 93) begin
                send_word(OP_PLAY, 1'b1);
            end else begin
                send_word(OP_PLAY, 1'b0);
                sounding = 1'b0;
            end
            random_words++;
        end
    endtask

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int phase_len;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setup: ticks and a stop word while stopped, start, ticks, re-excite, stop.
        send_word(OP_TICK, 1'b0);
        send_word(OP_PLAY, 1'b0);
        send_word(OP_TICK, 1'b1);
        send_word(OP_PLAY, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_PLAY, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_PLAY, 1'b0);
        send_word(OP_TICK, 1'b0);

        // Extreme gains on a short string drive the states into saturation.
        settle();
        write_reg(REG_CENTER_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_NEAR_GAIN, 32'h8000_0000);
        write_reg(REG_FAR_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_PAST_CENTER_GAIN, 32'h8000_0000);
        write_reg(REG_PAST_NEAR_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_POINT_COUNT, 32'd8);
        write_reg(REG_PICKUP_INDEX, 32'd3);
        write_reg(REG_EXCITE_INDEX, 32'd3);
        send_word(OP_PLAY, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b0);
        settle();
        write_reg(REG_CENTER_GAIN, 32'h8000_0000);
        send_word(OP_PLAY, 1'b1);
        send_word(OP_TICK, 1'b0);

        // Count beyond the grid, excitation and pickup on the last edge point.
        settle();
        write_reg(REG_CENTER_GAIN, 32'h0200_0000);
        write_reg(REG_NEAR_GAIN, 32'h0040_0000);
        write_reg(REG_FAR_GAIN, 32'h0001_0000);
        write_reg(REG_PAST_CENTER_GAIN, 32'hFF00_0000);
        write_reg(REG_PAST_NEAR_GAIN, 32'h0000_0000);
        write_reg(REG_POINT_COUNT, 32'd300);
        write_reg(REG_PICKUP_INDEX, 32'd255);
        write_reg(REG_EXCITE_INDEX, 32'd255);
        send_word(OP_PLAY, 1'b0);
        send_word(OP_PLAY, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b0);
        send_word(OP_TICK, 1'b0);

        // Count shrunk below five during play, then grown with indexes outside it.
        settle();
        write_reg(REG_POINT_COUNT, 32'd4);
        write_reg(REG_PICKUP_INDEX, 32'd2);
        write_reg(REG_EXCITE_INDEX, 32'd2);
        send_word(OP_PLAY, 1'b1);
        send_word(OP_TICK, 1'b0);
        settle();
        write_reg(REG_POINT_COUNT, 32'd20);
        write_reg(REG_PICKUP_INDEX, 32'd30);
        write_reg(REG_EXCITE_INDEX, 32'd40);
        send_word(OP_TICK, 1'b0);
        send_word(OP_PLAY, 1'b1);
        send_word(OP_TICK, 1'b0);
        send_word(OP_PLAY, 1'b0);
        sounding = 1'b0;

        while (random_words < 600) begin
            settle();
            write_random_setup();
            calm = ($urandom_range(0, 4) == 0);
            phase_len = (active_count > 64) ? $urandom_range(3, 8) : $urandom_range(15, 50);
            repeat (phase_len) random_word();
            if (sounding && $urandom_range(0, 9) < 4) begin
                send_word(OP_PLAY, 1'b0);
                sounding = 1'b0;
            end
        end
        calm = 1'b0;

        settle();
        if (fails == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
